>>> rtl/u8d_pkg.sv
// Shared types and constants for the UTF-8 to UTF-32 stream decoder.
`default_nettype none

package u8d_pkg;

    localparam int BYTE_WIDTH   = 8;
    localparam int CP_WIDTH     = 21;
    localparam int REASON_WIDTH = 2;
    localparam int REG_WIDTH    = 16;

    // Why a string ended.
    localparam logic [REASON_WIDTH-1:0] REASON_END     = 2'd0;
    localparam logic [REASON_WIDTH-1:0] REASON_LIMIT   = 2'd1;
    localparam logic [REASON_WIDTH-1:0] REASON_INVALID = 2'd2;

    // Configuration register indexes.
    localparam logic REG_MAX_CHARS    = 1'b0;
    localparam logic REG_OUT_CAPACITY = 1'b1;

    // Lead byte class boundaries and payload masks.
    localparam logic [BYTE_WIDTH-1:0] LEAD_CONT_END = 8'hC0;
    localparam logic [BYTE_WIDTH-1:0] LEAD_TWO      = 8'hC2;
    localparam logic [BYTE_WIDTH-1:0] LEAD_THREE    = 8'hE0;
    localparam logic [BYTE_WIDTH-1:0] LEAD_FOUR     = 8'hF0;
    localparam logic [BYTE_WIDTH-1:0] LEAD_BAD      = 8'hF5;
    localparam logic [BYTE_WIDTH-1:0] MASK_ONE      = 8'h7F;
    localparam logic [BYTE_WIDTH-1:0] MASK_TWO      = 8'h1F;
    localparam logic [BYTE_WIDTH-1:0] MASK_THREE    = 8'h0F;
    localparam logic [BYTE_WIDTH-1:0] MASK_FOUR     = 8'h07;
    localparam logic [BYTE_WIDTH-1:0] MASK_CONT     = 8'h3F;

    // Decoder state carried from byte to byte, apart from the character count.
    typedef struct packed {
        logic [1:0]          bytes_pending;
        logic [CP_WIDTH-1:0] accumulator;
        logic                discarding;
    } dec_state_t;

    // One result item.
    typedef struct packed {
        logic [CP_WIDTH-1:0]     code_point;
        logic                    is_terminator;
        logic [REASON_WIDTH-1:0] stop_reason;
    } dec_result_t;

endpackage

`default_nettype wire

>>> rtl/u8d_stream_if.sv
// Valid/ready channel interfaces for the byte input and the code point output.
`default_nettype none

interface u8d_byte_if
    import u8d_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [BYTE_WIDTH-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface u8d_cp_if
    import u8d_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [CP_WIDTH-1:0]     code_point;
    logic                    is_terminator;
    logic [REASON_WIDTH-1:0] stop_reason;

    modport source (output valid, output code_point, output is_terminator,
                    output stop_reason, input ready);
    modport sink   (input valid, input code_point, input is_terminator,
                    input stop_reason, output ready);
endinterface

`default_nettype wire

>>> rtl/u8d_decode.sv
// Combinational next-state and result logic for one input byte.
`default_nettype none

module u8d_decode
    import u8d_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)(
    input  wire logic [BYTE_WIDTH-1:0]  data_byte,
    input  wire dec_state_t             state,
    input  wire logic [COUNT_WIDTH-1:0] count,
    input  wire logic [REG_WIDTH-1:0]   max_chars,
    input  wire logic [REG_WIDTH-1:0]   out_capacity,
    output dec_state_t                  state_next,
    output logic [COUNT_WIDTH-1:0]      count_next,
    output logic                        result_valid,
    output dec_result_t                 result
);

    localparam int CMP_WIDTH = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;

    logic [CMP_WIDTH-1:0]    count_ext;
    logic [CMP_WIDTH-1:0]    max_ext;
    logic [CMP_WIDTH-1:0]    cap_ext;
    logic                    count_full;
    logic                    limit_hit;
    logic [CP_WIDTH-1:0]     acc_shift;
    logic                    term;
    logic                    term_drop;
    logic [REASON_WIDTH-1:0] term_reason;
    logic                    emit;
    logic [CP_WIDTH-1:0]     emit_value;

    assign count_ext  = CMP_WIDTH'(count);
    assign max_ext    = CMP_WIDTH'(max_chars);
    assign cap_ext    = CMP_WIDTH'(out_capacity);
    assign count_full = &count;
    assign limit_hit  = (count_ext >= max_ext) || (count_ext >= cap_ext) || count_full;
    assign acc_shift  = {state.accumulator[CP_WIDTH-7:0], data_byte[5:0]};

    always_comb
    begin
        state_next   = state;
        count_next   = count;
        result_valid = 1'b0;
        result       = '0;
        term         = 1'b0;
        term_drop    = 1'b0;
        term_reason  = REASON_END;
        emit         = 1'b0;
        emit_value   = '0;

        priority if (state.discarding)
        begin
            if (data_byte == '0)
            begin
                state_next = '0;
                count_next = '0;
            end
        end
        else if (state.bytes_pending != 2'd0)
        begin
            if (data_byte == '0)
            begin
                term        = 1'b1;
                term_reason = REASON_INVALID;
            end
            else
            begin
                state_next.accumulator   = acc_shift;
                state_next.bytes_pending = state.bytes_pending - 2'd1;
                if (state.bytes_pending == 2'd1)
                begin
                    emit       = 1'b1;
                    emit_value = acc_shift;
                end
            end
        end
        else if (data_byte == '0)
        begin
            term        = 1'b1;
            term_reason = REASON_END;
        end
        else if (limit_hit)
        begin
            term        = 1'b1;
            term_reason = REASON_LIMIT;
            term_drop   = 1'b1;
        end
        else if (data_byte < LEAD_CONT_END)
        begin
            emit       = 1'b1;
            emit_value = CP_WIDTH'(data_byte & MASK_ONE);
        end
        else if (data_byte >= LEAD_TWO && data_byte < LEAD_THREE)
        begin
            state_next.accumulator   = CP_WIDTH'(data_byte & MASK_TWO);
            state_next.bytes_pending = 2'd1;
        end
        else if (data_byte >= LEAD_THREE && data_byte < LEAD_FOUR)
        begin
            state_next.accumulator   = CP_WIDTH'(data_byte & MASK_THREE);
            state_next.bytes_pending = 2'd2;
        end
        else if (data_byte >= LEAD_FOUR && data_byte < LEAD_BAD)
        begin
            state_next.accumulator   = CP_WIDTH'(data_byte & MASK_FOUR);
            state_next.bytes_pending = 2'd3;
        end
        else
        begin
            term        = 1'b1;
            term_reason = REASON_INVALID;
            term_drop   = 1'b1;
        end

        // A character that decodes to zero is treated as an invalid sequence.
        if (emit && emit_value == '0)
        begin
            emit        = 1'b0;
            term        = 1'b1;
            term_reason = REASON_INVALID;
            term_drop   = 1'b1;
        end

        if (emit)
        begin
            result_valid      = 1'b1;
            result.code_point = emit_value;
            if (!count_full)
            begin
                count_next = count + COUNT_WIDTH'(1);
            end
        end

        if (term)
        begin
            result_valid             = 1'b1;
            result.is_terminator     = 1'b1;
            result.stop_reason       = term_reason;
            state_next.bytes_pending = 2'd0;
            state_next.accumulator   = '0;
            state_next.discarding    = term_drop;
            count_next               = '0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/utf8_to_utf32_stream_decoder_unit.sv
// Top level of the UTF-8 to UTF-32 stream decoder.
`default_nettype none

// The decoder takes one byte of a zero-terminated UTF-8 string per input
// transaction and returns at most one output transaction per byte: a 21-bit
// code point for each completed character, or a terminator that closes the
// string and tells why it ended (string end, character limit or output
// capacity reached, or an invalid sequence). After a limit or invalid stop the
// rest of the string, up to and including its zero byte, is dropped silently.
// Continuation bytes are not checked; each adds its low six bits. The decoder
// sustains one byte per clock cycle while the sink takes results: each byte
// is decoded in the cycle it is accepted, by a shift, mask and compare against
// the registered decoder state, into an output register. The byte input
// is ready whenever that output register is empty or is being emptied in the
// same cycle, so a waiting result never blocks the next byte once the sink
// takes it. The max_chars and out_capacity registers are written through the
// plain write port and apply from the next byte on; write them only while the
// decoder is idle. COUNT_WIDTH sets the width of the per-string character
// counter, which saturates at its maximum and also acts as a limit.

module utf8_to_utf32_stream_decoder_unit
    import u8d_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    u8d_byte_if.sink                  byte_ch,
    u8d_cp_if.source                  code_ch,
    input  wire logic                 we,
    input  wire logic                 index,
    input  wire logic [REG_WIDTH-1:0] wdata
);

    // Configuration registers.
    logic [REG_WIDTH-1:0] max_chars_reg;
    logic [REG_WIDTH-1:0] out_capacity_reg;

    // Decoder state that spans bytes of a string.
    dec_state_t             state_reg;
    dec_state_t             state_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;

    // Output register.
    logic        out_valid_reg;
    dec_result_t out_data_reg;

    logic        result_valid;
    dec_result_t result;
    logic        byte_accept;

    // Room for a new result when the output register is empty or drains now.
    assign byte_ch.ready = !out_valid_reg || code_ch.ready;
    assign byte_accept   = byte_ch.valid && byte_ch.ready;

    u8d_decode #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decode (
        .data_byte    (byte_ch.data_byte),
        .state        (state_reg),
        .count        (count_reg),
        .max_chars    (max_chars_reg),
        .out_capacity (out_capacity_reg),
        .state_next   (state_next),
        .count_next   (count_next),
        .result_valid (result_valid),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_chars_reg    <= '1;
            out_capacity_reg <= '1;
        end
        else if (we)
        begin
            unique case (index)
                REG_MAX_CHARS:    max_chars_reg    <= wdata;
                REG_OUT_CAPACITY: out_capacity_reg <= wdata;
                default:          max_chars_reg    <= max_chars_reg;
            endcase
        end
    end

    // State advances only on an accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            count_reg <= '0;
        end
        else if (byte_accept)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (byte_ch.ready)
        begin
            out_valid_reg <= byte_accept && result_valid;
        end
    end

    // Payload register: loaded only when a new result is produced.
    always_ff @(posedge clk)
    begin
        if (byte_accept && result_valid)
        begin
            out_data_reg <= result;
        end
    end

    assign code_ch.valid         = out_valid_reg;
    assign code_ch.code_point    = out_data_reg.code_point;
    assign code_ch.is_terminator = out_data_reg.is_terminator;
    assign code_ch.stop_reason   = out_data_reg.stop_reason;

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the UTF-8 to UTF-32 stream decoder.
`timescale 1ns / 1ps

module testbench;
    import u8d_pkg::*;

    localparam int COUNT_WIDTH = 16;
    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_WIDTH) - 1;
    // Hard stop on a hung run.
    localparam int LIMIT_CYCLES = 200000;
    // Cycles allowed for a byte still in flight when nothing is expected.
    localparam int SETTLE_CYCLES = 4;

    // Decodes the accepted byte stream on its own and checks every result
    // transaction against the oldest code point or terminator it predicted.
    class decode_checker;
        logic [REG_WIDTH-1:0] max_chars;
        logic [REG_WIDTH-1:0] out_capacity;
        logic [1:0]           cont_left;
        logic [CP_WIDTH-1:0]  partial_cp;
        longint unsigned      chars_in_string;
        bit                   dropping;
        dec_result_t          expected_results[$];
        int unsigned          failures;

        function new();
            max_chars       = '1;
            out_capacity    = '1;
            cont_left       = '0;
            partial_cp      = '0;
            chars_in_string = 0;
            dropping        = 1'b0;
            failures        = 0;
        endfunction

        // A terminator closes the string, so all per-string state starts over.
        function void push_terminator(logic [REASON_WIDTH-1:0] reason, bit drop_rest);
            dec_result_t r;
            r.code_point    = '0;
            r.is_terminator = 1'b1;
            r.stop_reason   = reason;
            expected_results.push_back(r);
            cont_left       = '0;
            partial_cp      = '0;
            chars_in_string = 0;
            dropping        = drop_rest;
        endfunction

        // A character that decodes to zero would look like an end of string,
        // so it is treated as an invalid sequence instead.
        function void push_char(logic [CP_WIDTH-1:0] value);
            dec_result_t r;
            if (value == '0)
                push_terminator(REASON_INVALID, 1'b1);
            else
            begin
                r.code_point    = value;
                r.is_terminator = 1'b0;
                r.stop_reason   = REASON_END;
                expected_results.push_back(r);
                if (chars_in_string < COUNT_MAX)
                    chars_in_string++;
            end
        endfunction

        function void note_byte(logic [BYTE_WIDTH-1:0] b);
            if (dropping)
            begin
                // Everything up to and including the zero byte is swallowed.
                if (b == '0)
                begin
                    dropping        = 1'b0;
                    cont_left       = '0;
                    partial_cp      = '0;
                    chars_in_string = 0;
                end
            end
            else if (cont_left != 0)
            begin
                // A zero inside a sequence ends the string as invalid, and
                // since the string is over there is nothing left to drop.
                if (b == '0)
                    push_terminator(REASON_INVALID, 1'b0);
                else
                begin
                    partial_cp = {partial_cp[CP_WIDTH-7:0], b[5:0]};
                    cont_left--;
                    if (cont_left == 0)
                        push_char(partial_cp);
                end
            end
            else if (b == '0)
                push_terminator(REASON_END, 1'b0);
            else if (chars_in_string >= max_chars || chars_in_string >= out_capacity ||
                     chars_in_string >= COUNT_MAX)
                push_terminator(REASON_LIMIT, 1'b1);
            else if (b < LEAD_CONT_END)
                push_char(CP_WIDTH'(b & MASK_ONE));
            else if (b >= LEAD_TWO && b < LEAD_THREE)
            begin
                partial_cp = CP_WIDTH'(b & MASK_TWO);
                cont_left  = 2'd1;
            end
            else if (b >= LEAD_THREE && b < LEAD_FOUR)
            begin
                partial_cp = CP_WIDTH'(b & MASK_THREE);
                cont_left  = 2'd2;
            end
            else if (b >= LEAD_FOUR && b < LEAD_BAD)
            begin
                partial_cp = CP_WIDTH'(b & MASK_FOUR);
                cont_left  = 2'd3;
            end
            else
                push_terminator(REASON_INVALID, 1'b1);
        endfunction

        function void check_code_point(logic [CP_WIDTH-1:0] cp, logic term,
                                       logic [REASON_WIDTH-1:0] reason);
            dec_result_t want;
            if (expected_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: code_point=%h is_terminator=%b",
                             cp, term, " stop_reason=%0d", reason);
            end
            else
            begin
                want = expected_results.pop_front();
                if (want.code_point !== cp || want.is_terminator !== term ||
                    want.stop_reason !== reason)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("mismatch: expected code_point=%h is_terminator=%b",
                                 want.code_point, want.is_terminator,
                                 " stop_reason=%0d,", want.stop_reason,
                                 " got code_point=%h is_terminator=%b", cp, term,
                                 " stop_reason=%0d", reason);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic we;
    logic index;
    logic [REG_WIDTH-1:0] wdata;

    u8d_byte_if byte_ch ();
    u8d_cp_if   code_ch ();

    decode_checker checker_h;

    // Idling knobs, in percent per transaction or per cycle; zero means none.
    int gap_pct;
    int stall_pct;
    int bytes_sent;
    int cycle_count;

    utf8_to_utf32_stream_decoder_unit #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .byte_ch(byte_ch),
        .code_ch(code_ch),
        .we     (we),
        .index  (index),
        .wdata  (wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Both channels are observed at the rising edge, where the stimulus set
    // up at the previous falling edge is stable. A result accepted at this
    // edge always comes from a byte accepted at an earlier edge, so noting
    // the input first never lets a fresh prediction jump the queue.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_ch.valid && byte_ch.ready)
                checker_h.note_byte(byte_ch.data_byte);
            if (code_ch.valid && code_ch.ready)
                checker_h.check_code_point(code_ch.code_point, code_ch.is_terminator,
                                           code_ch.stop_reason);
        end
    end

    // Watchdog: a stuck handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // The result side stalls in bursts of random length. When stall_pct is
    // zero the sink simply takes every result as soon as it shows up.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        code_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_pct == 0)
                stall_left = 0;
            if (stall_left == 0 && $urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(1, 13);
            if (stall_left > 0)
            begin
                stall_left--;
                code_ch.ready <= 1'b0;
            end
            else
                code_ch.ready <= 1'b1;
        end
    end

    // Presents one byte and holds it until the decoder takes it. The task is
    // entered and left at a falling edge with valid still high, so a byte
    // that follows straight away never sees valid dropped and raised in the
    // same step. Whoever stops sending must lower valid right away.
    task automatic send_byte(input logic [BYTE_WIDTH-1:0] value);
        int gap;
        if ($urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 13);
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= value;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Brings the decoder to idle: no byte offered, every predicted result
    // returned, and SETTLE_CYCLES more for a last byte that produced nothing.
    task automatic settle();
        byte_ch.valid <= 1'b0;
        while (checker_h.expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One register write; the trailing wait keeps two writes in a row from
    // lowering and raising the write enable in the same step.
    task automatic write_reg(input logic reg_sel, input logic [REG_WIDTH-1:0] value);
        we    <= 1'b1;
        index <= reg_sel;
        wdata <= value;
        @(negedge clk);
        we <= 1'b0;
        if (reg_sel == REG_MAX_CHARS)
            checker_h.max_chars = value;
        else
            checker_h.out_capacity = value;
        @(negedge clk);
    endtask

    // Sends one zero-terminated string. Most characters are well formed with
    // random payloads; a minority are invalid leads, stray bytes, or
    // sequences cut short by the zero byte.
    task automatic send_string();
        int n_chars;
        int pick;
        int n_cont;
        int n_sent_cont;
        bit cut_short;
        logic [BYTE_WIDTH-1:0] lead;
        n_chars = $urandom_range(0, 9);
        for (int c = 0; c < n_chars; c++)
        begin
            pick      = $urandom_range(0, 99);
            n_cont    = 0;
            cut_short = 1'b0;
            if (pick < 30)
                lead = BYTE_WIDTH'($urandom_range(1, 127));
            else if (pick < 35)
                lead = BYTE_WIDTH'($urandom_range(128, 191));
            else if (pick < 55)
            begin
                lead   = BYTE_WIDTH'($urandom_range(194, 223));
                n_cont = 1;
            end
            else if (pick < 72)
            begin
                lead   = BYTE_WIDTH'($urandom_range(224, 239));
                n_cont = 2;
            end
            else if (pick < 87)
            begin
                lead   = BYTE_WIDTH'($urandom_range(240, 244));
                n_cont = 3;
            end
            else if (pick < 92)
                lead = $urandom_range(0, 1) ? BYTE_WIDTH'($urandom_range(192, 193))
                                            : BYTE_WIDTH'($urandom_range(245, 255));
            else if (pick < 96)
                lead = BYTE_WIDTH'($urandom_range(1, 255));
            else
            begin
                lead      = BYTE_WIDTH'($urandom_range(194, 244));
                n_cont    = (lead < LEAD_THREE) ? 1 : (lead < LEAD_FOUR) ? 2 : 3;
                cut_short = 1'b1;
            end
            send_byte(lead);
            n_sent_cont = cut_short ? $urandom_range(0, n_cont - 1) : n_cont;
            // Continuation bytes are not checked, so now and then any
            // nonzero byte stands in for one.
            for (int k = 0; k < n_sent_cont; k++)
                send_byte($urandom_range(0, 7) == 0 ? BYTE_WIDTH'($urandom_range(1, 255))
                                                    : BYTE_WIDTH'($urandom_range(128, 191)));
            if (cut_short)
            begin
                send_byte('0);
                return;
            end
        end
        send_byte('0);
    endtask

    task automatic run_phase(input logic [REG_WIDTH-1:0] max_val,
                             input logic [REG_WIDTH-1:0] cap_val,
                             input int gap, input int stall, input int n_bytes);
        int start_count;
        settle();
        write_reg(REG_MAX_CHARS, max_val);
        write_reg(REG_OUT_CAPACITY, cap_val);
        gap_pct     = gap;
        stall_pct   = stall;
        start_count = bytes_sent;
        while (bytes_sent - start_count < n_bytes)
            send_string();
    endtask

    initial
    begin : stimulus
        logic [BYTE_WIDTH-1:0] directed_seq[$];
        checker_h         = new();
        rst_n             = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        we                = 1'b0;
        index             = REG_MAX_CHARS;
        wdata             = '0;
        gap_pct           = 0;
        stall_pct         = 0;
        bytes_sent        = 0;
        cycle_count       = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed string set, with both registers at their reset values:
        //   one-byte extremes, a continuation byte used as a lead, and the
        //   smallest two-byte character, then a normal end;
        //   the largest two-byte and four-byte characters;
        //   an overlong lead whose string is dropped up to its zero byte;
        //   the top byte value as a lead;
        //   a lead that decodes to zero on its own;
        //   an overlong three-byte sequence that decodes to zero;
        //   a zero byte in the middle of a sequence, which ends the string
        //   without a drop, so the next zero is an empty string;
        //   the first invalid four-byte lead.
        directed_seq = '{8'h01, 8'h7F, 8'hBF, 8'hC2, 8'h80, 8'h00,
                         8'hDF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00,
                         8'hC0, 8'h41, 8'h00,
                         8'hFF, 8'h00,
                         8'h80, 8'h00,
                         8'hE0, 8'h80, 8'h80, 8'h00,
                         8'hE2, 8'h00, 8'h00,
                         8'hF5, 8'h00};
        gap_pct   = 20;
        stall_pct = 20;
        foreach (directed_seq[i])
            send_byte(directed_seq[i]);

        // Random strings under a range of limits, from none at all to zero,
        // each phase with its own amount of idling on both sides.
        run_phase(16'd3,     16'hFFFF, 30, 30, 60);
        run_phase(16'hFFFF,  16'd5,     0,  0, 60);
        run_phase(16'd0,     16'hFFFF, 15, 40, 40);
        run_phase(16'hFFFF,  16'd0,    40, 15, 40);
        run_phase(16'd1,     16'd1,    20, 20, 50);
        run_phase(REG_WIDTH'($urandom_range(2, 8)), REG_WIDTH'($urandom_range(2, 8)),
                  30, 30, 100);
        // The closing stretch runs flat out, with no idling at all.
        run_phase(16'hFFFF,  16'hFFFF,  0,  0, 80);

        byte_ch.valid <= 1'b0;
        while (checker_h.expected_results.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (checker_h.failures == 0 && checker_h.expected_results.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
